[rtl/qibm_pkg.sv]
`default_nettype none

package qibm_pkg;

    localparam int OUT_INT_BITS = 2;
    localparam int QUEUE_AW = 2;

endpackage

`default_nettype wire

[rtl/qibm_front.sv]
`default_nettype none

module qibm_front #(
    parameter int W = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [W-1:0]     corner1_x,
    input  logic signed [W-1:0]     corner1_y,
    input  logic signed [W-1:0]     corner2_x,
    input  logic signed [W-1:0]     corner2_y,
    input  logic signed [W-1:0]     corner3_x,
    input  logic signed [W-1:0]     corner3_y,
    input  logic signed [W-1:0]     corner4_x,
    input  logic signed [W-1:0]     corner4_y,
    input  logic signed [W-1:0]     point_x,
    input  logic signed [W-1:0]     point_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [4*W+14:0]  out_rr,
    output logic signed [4*W+14:0]  out_rs,
    output logic signed [2*W+6:0]   out_br,
    output logic signed [2*W+6:0]   out_bs,
    output logic signed [2*W+5:0]   out_cr,
    output logic signed [2*W+5:0]   out_cs
);

    import qibm_pkg::*;

    localparam int DW = W + 1;
    localparam int SW = W + 2;
    localparam int XW = W + 3;
    localparam int PW = 2 * DW;
    localparam int TW = XW + SW;
    localparam int BW = 2 * W + 7;
    localparam int CW = 2 * W + 6;
    localparam int JW = 2 * W + 3;
    localparam int LW = (BW + 1) / 2;
    localparam int HW = BW - LW;
    localparam int HH = 2 * HW;
    localparam int HL = HW + LW + 1;
    localparam int LL = 2 * LW;
    localparam int MW = 2 * BW;
    localparam int RW = 4 * W + 15;
    localparam int NST = 6;

    logic [NST-1:0] v_reg, v_next;
    logic           en;

    logic signed [DW-1:0] pa_reg [6], pa_next [6];
    logic signed [DW-1:0] pb_reg [6], pb_next [6];
    logic signed [SW-1:0] twx_reg, twy_reg, arx_reg, ary_reg, asx_reg, asy_reg;
    logic signed [SW-1:0] twx_next, twy_next, arx_next, ary_next, asx_next, asy_next;
    logic signed [XW-1:0] dxs_reg, dys_reg, dxs_next, dys_next;

    logic signed [PW-1:0] pp_reg [6], pp_next [6];
    logic signed [TW-1:0] tp_reg [6], tp_next [6];

    logic signed [BW-1:0] opa_reg [4], opa_next [4];
    logic signed [BW-1:0] opb_reg [4], opb_next [4];

    logic signed [HH-1:0] hh_reg [4], hh_next [4];
    logic signed [HL-1:0] hl_reg [4], hl_next [4];
    logic signed [HL-1:0] lh_reg [4], lh_next [4];
    logic        [LL-1:0] ll_reg [4], ll_next [4];
    logic signed [BW-1:0] br4_reg, bs4_reg, cr4_reg, cs4_reg;

    logic signed [MW-1:0] prod_reg [4], prod_next [4];
    logic signed [BW-1:0] br5_reg, bs5_reg, cr5_reg, cs5_reg;

    logic signed [RW-1:0] rr_reg, rs_reg, rr_next, rs_next;
    logic signed [BW-1:0] br6_reg, bs6_reg, cr6_reg, cs6_reg;

    logic signed [BW-1:0] p2_w, t_w;

    assign en        = !v_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[NST-1];
    assign v_next    = {v_reg[NST-2:0], in_valid};

    always_comb
    begin
        pa_next[0] = DW'(corner3_x) - DW'(corner1_x);
        pb_next[0] = DW'(corner4_y) - DW'(corner2_y);
        pa_next[1] = DW'(corner4_x) - DW'(corner2_x);
        pb_next[1] = DW'(corner3_y) - DW'(corner1_y);
        pa_next[2] = DW'(corner3_x) - DW'(corner4_x);
        pb_next[2] = DW'(corner1_y) - DW'(corner2_y);
        pa_next[3] = DW'(corner1_x) - DW'(corner2_x);
        pb_next[3] = DW'(corner3_y) - DW'(corner4_y);
        pa_next[4] = DW'(corner2_x) - DW'(corner3_x);
        pb_next[4] = DW'(corner1_y) - DW'(corner4_y);
        pa_next[5] = DW'(corner1_x) - DW'(corner4_x);
        pb_next[5] = DW'(corner2_y) - DW'(corner3_y);
        twx_next = SW'(corner1_x) - SW'(corner2_x) + SW'(corner3_x) - SW'(corner4_x);
        twy_next = SW'(corner1_y) - SW'(corner2_y) + SW'(corner3_y) - SW'(corner4_y);
        arx_next = SW'(corner1_x) + SW'(corner2_x) - SW'(corner3_x) - SW'(corner4_x);
        ary_next = SW'(corner1_y) + SW'(corner2_y) - SW'(corner3_y) - SW'(corner4_y);
        asx_next = SW'(corner1_x) - SW'(corner2_x) - SW'(corner3_x) + SW'(corner4_x);
        asy_next = SW'(corner1_y) - SW'(corner2_y) - SW'(corner3_y) + SW'(corner4_y);
        dxs_next = (XW'(point_x) <<< 2) - XW'(corner1_x) - XW'(corner2_x)
                   - XW'(corner3_x) - XW'(corner4_x);
        dys_next = (XW'(point_y) <<< 2) - XW'(corner1_y) - XW'(corner2_y)
                   - XW'(corner3_y) - XW'(corner4_y);
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            pp_next[k] = PW'(pa_reg[k]) * PW'(pb_reg[k]);
        end
        tp_next[0] = TW'(dys_reg) * TW'(twx_reg);
        tp_next[1] = TW'(dxs_reg) * TW'(twy_reg);
        tp_next[2] = TW'(dxs_reg) * TW'(ary_reg);
        tp_next[3] = TW'(dys_reg) * TW'(arx_reg);
        tp_next[4] = TW'(dxs_reg) * TW'(asy_reg);
        tp_next[5] = TW'(dys_reg) * TW'(asx_reg);
    end

    assign p2_w = (BW'(pp_reg[0]) - BW'(pp_reg[1])) <<< 1;
    assign t_w  = BW'(tp_reg[0]) - BW'(tp_reg[1]);

    always_comb
    begin
        opa_next[0] = p2_w + t_w;
        opb_next[0] = p2_w + t_w;
        opa_next[1] = BW'(JW'(pp_reg[2]) - JW'(pp_reg[3]));
        opb_next[1] = BW'(CW'(tp_reg[2]) - CW'(tp_reg[3]));
        opa_next[2] = t_w - p2_w;
        opb_next[2] = t_w - p2_w;
        opa_next[3] = BW'(JW'(pp_reg[4]) - JW'(pp_reg[5]));
        opb_next[3] = BW'(CW'(tp_reg[4]) - CW'(tp_reg[5]));
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            hh_next[k] = HH'($signed(opa_reg[k][BW-1:LW]))
                         * HH'($signed(opb_reg[k][BW-1:LW]));
            hl_next[k] = HL'($signed(opa_reg[k][BW-1:LW]))
                         * HL'($signed({1'b0, opb_reg[k][LW-1:0]}));
            lh_next[k] = HL'($signed({1'b0, opa_reg[k][LW-1:0]}))
                         * HL'($signed(opb_reg[k][BW-1:LW]));
            ll_next[k] = LL'(opa_reg[k][LW-1:0]) * LL'(opb_reg[k][LW-1:0]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_next[k] = (MW'(hh_reg[k]) <<< (2 * LW))
                           + ((MW'(hl_reg[k]) + MW'(lh_reg[k])) <<< LW)
                           + $signed({{(MW - LL){1'b0}}, ll_reg[k]});
        end
    end

    assign rr_next = RW'(prod_reg[0]) - (RW'(prod_reg[1]) <<< 3);
    assign rs_next = RW'(prod_reg[2]) + (RW'(prod_reg[3]) <<< 3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            twx_reg <= twx_next;
            twy_reg <= twy_next;
            arx_reg <= arx_next;
            ary_reg <= ary_next;
            asx_reg <= asx_next;
            asy_reg <= asy_next;
            dxs_reg <= dxs_next;
            dys_reg <= dys_next;
            pp_reg  <= pp_next;
            tp_reg  <= tp_next;
            opa_reg <= opa_next;
            opb_reg <= opb_next;
            hh_reg  <= hh_next;
            hl_reg  <= hl_next;
            lh_reg  <= lh_next;
            ll_reg  <= ll_next;
            br4_reg <= opa_reg[0];
            bs4_reg <= opa_reg[2];
            cr4_reg <= opb_reg[1];
            cs4_reg <= opb_reg[3];
            prod_reg <= prod_next;
            br5_reg <= br4_reg;
            bs5_reg <= bs4_reg;
            cr5_reg <= cr4_reg;
            cs5_reg <= cs4_reg;
            rr_reg  <= rr_next;
            rs_reg  <= rs_next;
            br6_reg <= br5_reg;
            bs6_reg <= bs5_reg;
            cr6_reg <= cr5_reg;
            cs6_reg <= cs5_reg;
        end
    end

    assign out_rr = rr_reg;
    assign out_rs = rs_reg;
    assign out_br = br6_reg;
    assign out_bs = bs6_reg;
    assign out_cr = CW'(cr6_reg);
    assign out_cs = CW'(cs6_reg);

endmodule

`default_nettype wire

[rtl/qibm_queue.sv]
`default_nettype none

module qibm_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    import qibm_pkg::*;

    localparam int DEPTH = 1 << QUEUE_AW;

    logic [DATA_W-1:0]   entry_reg [DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push, pop;

    assign push_ready = count_reg != (QUEUE_AW + 1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/qibm_back.sv]
`default_nettype none

module qibm_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [4*W+14:0]                 in_rr,
    input  logic signed [4*W+14:0]                 in_rs,
    input  logic signed [2*W+6:0]                  in_br,
    input  logic signed [2*W+6:0]                  in_bs,
    input  logic signed [2*W+5:0]                  in_cr,
    input  logic signed [2*W+5:0]                  in_cs,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [F+qibm_pkg::OUT_INT_BITS-1:0] out_r,
    output logic signed [F+qibm_pkg::OUT_INT_BITS-1:0] out_s,
    output logic                                   out_inside,
    output logic                                   out_invalid
);

    import qibm_pkg::*;

    localparam int BW  = 2 * W + 7;
    localparam int CW  = 2 * W + 6;
    localparam int RW  = 4 * W + 15;
    localparam int QW  = BW;
    localparam int DNW = BW + 2;
    localparam int QT  = F + 4;
    localparam int XW  = 2 * W + F + 14;
    localparam int OW  = F + OUT_INT_BITS;
    localparam int NS  = QW + QT + 5;

    localparam logic [QT-1:0] LIM_Q = {{(QT-1){1'b0}}, 1'b1} << (F + 1);
    localparam logic [QT-1:0] MAXP_Q = LIM_Q - 1'b1;
    localparam logic signed [OW-1:0] ONE_Q = OW'(1) <<< F;
    localparam logic signed [OW-1:0] NEG_ONE_Q = -ONE_Q;

    logic [NS-1:0] v_reg, v_next;
    logic          en;

    logic [RW-1:0]        srem_r_reg [QW+1], srem_s_reg [QW+1];
    logic [QW-1:0]        sroot_r_reg [QW+1], sroot_s_reg [QW+1];
    logic signed [BW-1:0] sbr_reg [QW+1], sbs_reg [QW+1];
    logic signed [CW-1:0] scr_reg [QW+1], scs_reg [QW+1];
    logic                 sbad_reg [QW+1];
    logic [RW-1:0]        srem_r_next [QW], srem_s_next [QW];
    logic [QW-1:0]        sroot_r_next [QW], sroot_s_next [QW];
    logic                 entry_bad;

    logic signed [DNW-1:0] dr_reg, ds_reg, dr_next, ds_next;
    logic [CW-1:0]         acr_reg, acs_reg, acr_next, acs_next;
    logic                  crs_reg, css_reg, dbad_reg;

    logic [DNW-1:0]        ad_r_reg, ad_s_reg;
    logic [CW-1:0]         pcr_reg, pcs_reg;
    logic                  neg_r_reg, neg_s_reg, pbad_reg;

    logic [XW-1:0]         drem_r_reg [QT+1], drem_s_reg [QT+1];
    logic [DNW-1:0]        dd_r_reg [QT+1], dd_s_reg [QT+1];
    logic [QT-1:0]         dq_r_reg [QT+1], dq_s_reg [QT+1];
    logic                  dneg_r_reg [QT+1], dneg_s_reg [QT+1], dvbad_reg [QT+1];
    logic [XW-1:0]         drem_r_next [QT], drem_s_next [QT];
    logic [QT-1:0]         dq_r_next [QT], dq_s_next [QT];

    logic signed [OW-1:0]  r_next, s_next, r_reg, s_reg;
    logic                  inside_next, inside_reg, invalid_reg;

    assign en        = !v_reg[NS-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[NS-1];
    assign v_next    = {v_reg[NS-2:0], in_valid};
    assign entry_bad = in_rr[RW-1] || in_rs[RW-1];

    for (genvar j = 0; j < QW; j++)
    begin : g_sqrt
        localparam int I = QW - 1 - j;
        logic [RW-1:0] tr_r, tr_s;
        logic          take_r, take_s;
        assign tr_r = (RW'(sroot_r_reg[j]) << (I + 1)) + (RW'(1'b1) << (2 * I));
        assign tr_s = (RW'(sroot_s_reg[j]) << (I + 1)) + (RW'(1'b1) << (2 * I));
        assign take_r = srem_r_reg[j] >= tr_r;
        assign take_s = srem_s_reg[j] >= tr_s;
        assign srem_r_next[j]  = take_r ? srem_r_reg[j] - tr_r : srem_r_reg[j];
        assign srem_s_next[j]  = take_s ? srem_s_reg[j] - tr_s : srem_s_reg[j];
        assign sroot_r_next[j] = take_r ? (sroot_r_reg[j] | (QW'(1'b1) << I))
                                        : sroot_r_reg[j];
        assign sroot_s_next[j] = take_s ? (sroot_s_reg[j] | (QW'(1'b1) << I))
                                        : sroot_s_reg[j];
    end

    assign dr_next  = -DNW'($signed({1'b0, sroot_r_reg[QW]})) - DNW'(sbr_reg[QW]);
    assign ds_next  = DNW'($signed({1'b0, sroot_s_reg[QW]})) - DNW'(sbs_reg[QW]);
    assign acr_next = scr_reg[QW][CW-1] ? CW'(-scr_reg[QW]) : CW'(scr_reg[QW]);
    assign acs_next = scs_reg[QW][CW-1] ? CW'(-scs_reg[QW]) : CW'(scs_reg[QW]);

    for (genvar j = 0; j < QT; j++)
    begin : g_div
        localparam int I = QT - 1 - j;
        logic [XW-1:0] tr_r, tr_s;
        logic          take_r, take_s;
        assign tr_r = XW'(dd_r_reg[j]) << (I + 1);
        assign tr_s = XW'(dd_s_reg[j]) << (I + 1);
        assign take_r = drem_r_reg[j] >= tr_r;
        assign take_s = drem_s_reg[j] >= tr_s;
        assign drem_r_next[j] = take_r ? drem_r_reg[j] - tr_r : drem_r_reg[j];
        assign drem_s_next[j] = take_s ? drem_s_reg[j] - tr_s : drem_s_reg[j];
        assign dq_r_next[j] = take_r ? (dq_r_reg[j] | (QT'(1'b1) << I)) : dq_r_reg[j];
        assign dq_s_next[j] = take_s ? (dq_s_reg[j] | (QT'(1'b1) << I)) : dq_s_reg[j];
    end

    always_comb
    begin
        r_next = '0;
        s_next = '0;
        if (!dvbad_reg[QT])
        begin
            if (dneg_r_reg[QT])
            begin
                r_next = (dq_r_reg[QT] > LIM_Q) ? OW'(0) - OW'(LIM_Q)
                                                : OW'(0) - OW'(dq_r_reg[QT]);
            end
            else
            begin
                r_next = (dq_r_reg[QT] > MAXP_Q) ? OW'(MAXP_Q) : OW'(dq_r_reg[QT]);
            end
            if (dneg_s_reg[QT])
            begin
                s_next = (dq_s_reg[QT] > LIM_Q) ? OW'(0) - OW'(LIM_Q)
                                                : OW'(0) - OW'(dq_s_reg[QT]);
            end
            else
            begin
                s_next = (dq_s_reg[QT] > MAXP_Q) ? OW'(MAXP_Q) : OW'(dq_s_reg[QT]);
            end
        end
        inside_next = !dvbad_reg[QT] && r_next >= NEG_ONE_Q && r_next <= ONE_Q
                      && s_next >= NEG_ONE_Q && s_next <= ONE_Q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srem_r_reg[0]  <= entry_bad ? '0 : RW'(in_rr);
            srem_s_reg[0]  <= entry_bad ? '0 : RW'(in_rs);
            sroot_r_reg[0] <= '0;
            sroot_s_reg[0] <= '0;
            sbr_reg[0]     <= in_br;
            sbs_reg[0]     <= in_bs;
            scr_reg[0]     <= in_cr;
            scs_reg[0]     <= in_cs;
            sbad_reg[0]    <= entry_bad;
            for (int k = 1; k <= QW; k++)
            begin
                srem_r_reg[k]  <= srem_r_next[k-1];
                srem_s_reg[k]  <= srem_s_next[k-1];
                sroot_r_reg[k] <= sroot_r_next[k-1];
                sroot_s_reg[k] <= sroot_s_next[k-1];
                sbr_reg[k]     <= sbr_reg[k-1];
                sbs_reg[k]     <= sbs_reg[k-1];
                scr_reg[k]     <= scr_reg[k-1];
                scs_reg[k]     <= scs_reg[k-1];
                sbad_reg[k]    <= sbad_reg[k-1];
            end

            dr_reg   <= dr_next;
            ds_reg   <= ds_next;
            acr_reg  <= acr_next;
            acs_reg  <= acs_next;
            crs_reg  <= scr_reg[QW][CW-1];
            css_reg  <= scs_reg[QW][CW-1];
            dbad_reg <= sbad_reg[QW];

            ad_r_reg  <= dr_reg[DNW-1] ? DNW'(-dr_reg) : DNW'(dr_reg);
            ad_s_reg  <= ds_reg[DNW-1] ? DNW'(-ds_reg) : DNW'(ds_reg);
            pcr_reg   <= acr_reg;
            pcs_reg   <= acs_reg;
            neg_r_reg <= crs_reg ^ dr_reg[DNW-1];
            neg_s_reg <= css_reg ^ ds_reg[DNW-1];
            pbad_reg  <= dbad_reg || dr_reg == '0 || ds_reg == '0;

            drem_r_reg[0] <= (XW'(pcr_reg) << (F + 2)) + XW'(ad_r_reg);
            drem_s_reg[0] <= (XW'(pcs_reg) << (F + 2)) + XW'(ad_s_reg);
            dd_r_reg[0]   <= ad_r_reg;
            dd_s_reg[0]   <= ad_s_reg;
            dq_r_reg[0]   <= '0;
            dq_s_reg[0]   <= '0;
            dneg_r_reg[0] <= neg_r_reg;
            dneg_s_reg[0] <= neg_s_reg;
            dvbad_reg[0]  <= pbad_reg;
            for (int k = 1; k <= QT; k++)
            begin
                drem_r_reg[k] <= drem_r_next[k-1];
                drem_s_reg[k] <= drem_s_next[k-1];
                dd_r_reg[k]   <= dd_r_reg[k-1];
                dd_s_reg[k]   <= dd_s_reg[k-1];
                dq_r_reg[k]   <= dq_r_next[k-1];
                dq_s_reg[k]   <= dq_s_next[k-1];
                dneg_r_reg[k] <= dneg_r_reg[k-1];
                dneg_s_reg[k] <= dneg_s_reg[k-1];
                dvbad_reg[k]  <= dvbad_reg[k-1];
            end

            r_reg       <= r_next;
            s_reg       <= s_next;
            inside_reg  <= inside_next;
            invalid_reg <= dvbad_reg[QT];
        end
    end

    assign out_r       = r_reg;
    assign out_s       = s_reg;
    assign out_inside  = inside_reg;
    assign out_invalid = invalid_reg;

endmodule

`default_nettype wire

[rtl/quad_inverse_bilinear_map_unit.sv]
`default_nettype none
// Inverse bilinear map of a point into a quadrilateral's local (r, s) frame.
// Input channel (in_valid/in_ready): four corners and a query point, signed
// fixed point with FRAC_BITS fraction bits. Output channel (out_valid/
// out_ready): local_r and local_s in signed Q2.FRAC_BITS, rounded to nearest
// and saturated, inside_res when both lie in [-1,1], and invalid when a
// radicand is negative or a denominator is zero (coordinates then read 0).
// Throughput: one item per cycle while out_ready is high. Each item passes
// the bit-per-stage square root (2*COORD_WIDTH + 7 stages) and the
// restoring divider (FRAC_BITS + 4 stages). A six-stage front pipeline forms
// the radicands and feeds a four-entry queue ahead of the root/divide
// pipeline. When out_ready is low, the back pipeline holds, the queue fills
// and then the front holds; no item is lost. Reset empties all stages and
// the queue.
module quad_inverse_bilinear_map_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_WIDTH-1:0]         corner1_x,
    input  logic signed [COORD_WIDTH-1:0]         corner1_y,
    input  logic signed [COORD_WIDTH-1:0]         corner2_x,
    input  logic signed [COORD_WIDTH-1:0]         corner2_y,
    input  logic signed [COORD_WIDTH-1:0]         corner3_x,
    input  logic signed [COORD_WIDTH-1:0]         corner3_y,
    input  logic signed [COORD_WIDTH-1:0]         corner4_x,
    input  logic signed [COORD_WIDTH-1:0]         corner4_y,
    input  logic signed [COORD_WIDTH-1:0]         point_x,
    input  logic signed [COORD_WIDTH-1:0]         point_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [FRAC_BITS+qibm_pkg::OUT_INT_BITS-1:0] local_r,
    output logic signed [FRAC_BITS+qibm_pkg::OUT_INT_BITS-1:0] local_s,
    output logic                                  inside_res,
    output logic                                  invalid
);

    import qibm_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int BW  = 2 * W + 7;
    localparam int CW  = 2 * W + 6;
    localparam int RW  = 4 * W + 15;
    localparam int QDW = 2 * RW + 2 * BW + 2 * CW;
    localparam int OW  = FRAC_BITS + OUT_INT_BITS;

    localparam logic signed [OW-1:0] ONE_Q = OW'(1) <<< FRAC_BITS;
    localparam logic signed [OW-1:0] NEG_ONE_Q = -ONE_Q;

    logic                 f_valid, f_ready;
    logic signed [RW-1:0] f_rr, f_rs, b_rr, b_rs;
    logic signed [BW-1:0] f_br, f_bs, b_br, b_bs;
    logic signed [CW-1:0] f_cr, f_cs, b_cr, b_cs;
    logic [QDW-1:0]       q_push_data, q_pop_data;
    logic                 q_pop_valid, q_pop_ready;

    qibm_front #(
        .W(W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .corner1_x(corner1_x),
        .corner1_y(corner1_y),
        .corner2_x(corner2_x),
        .corner2_y(corner2_y),
        .corner3_x(corner3_x),
        .corner3_y(corner3_y),
        .corner4_x(corner4_x),
        .corner4_y(corner4_y),
        .point_x(point_x),
        .point_y(point_y),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_rr(f_rr),
        .out_rs(f_rs),
        .out_br(f_br),
        .out_bs(f_bs),
        .out_cr(f_cr),
        .out_cs(f_cs)
    );

    assign q_push_data = {f_rr, f_rs, f_br, f_bs, f_cr, f_cs};

    qibm_queue #(
        .DATA_W(QDW)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(f_valid),
        .push_ready(f_ready),
        .push_data(q_push_data),
        .pop_valid(q_pop_valid),
        .pop_ready(q_pop_ready),
        .pop_data(q_pop_data)
    );

    assign b_cs = $signed(q_pop_data[0 +: CW]);
    assign b_cr = $signed(q_pop_data[CW +: CW]);
    assign b_bs = $signed(q_pop_data[2*CW +: BW]);
    assign b_br = $signed(q_pop_data[2*CW+BW +: BW]);
    assign b_rs = $signed(q_pop_data[2*CW+2*BW +: RW]);
    assign b_rr = $signed(q_pop_data[2*CW+2*BW+RW +: RW]);

    qibm_back #(
        .W(W),
        .F(FRAC_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(q_pop_valid),
        .in_ready(q_pop_ready),
        .in_rr(b_rr),
        .in_rs(b_rs),
        .in_br(b_br),
        .in_bs(b_bs),
        .in_cr(b_cr),
        .in_cs(b_cs),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_r(local_r),
        .out_s(local_s),
        .out_inside(inside_res),
        .out_invalid(invalid)
    );

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> !inside_res && local_r == '0 && local_s == '0)
        else $error("invalid item carries nonzero result");

    a_inside_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> local_r <= ONE_Q && local_r >= NEG_ONE_Q
                                    && local_s <= ONE_Q && local_s >= NEG_ONE_Q)
        else $error("inside flag set outside unit square");

endmodule

`default_nettype wire
